FILE: hw/rtl/mcsr_pkg.sv
// ----------------------------------------------------------------------------
// mcsr_pkg
// shared types, protocol codes and the formatted card image for the
// memory card serial responder
// ----------------------------------------------------------------------------
package mcsr_pkg;

	localparam int FRAME_BYTES = 128;
	localparam int OFS_W       = 7;
	localparam int FADDR_W     = 10;

	// host bytes
	localparam logic [7:0] HB_ACCESS = 8'h81;
	localparam logic [7:0] HB_READ   = 8'h52;
	localparam logic [7:0] HB_WRITE  = 8'h57;
	localparam logic [7:0] HB_GETID  = 8'h53;

	// card reply bytes
	localparam logic [7:0] RB_ID1    = 8'h5A;
	localparam logic [7:0] RB_ID2    = 8'h5D;
	localparam logic [7:0] RB_ACK1   = 8'h5C;
	localparam logic [7:0] RB_ACK2   = 8'h5D;
	localparam logic [7:0] RB_END    = 8'h47;
	localparam logic [7:0] RB_SIZE   = 8'h04;
	localparam logic [7:0] RB_SECTOR = 8'h80;
	localparam logic [7:0] RB_IDLE   = 8'hFF;
	localparam logic [7:0] RB_ZERO   = 8'h00;
	localparam logic [7:0] RB_FLAG_NEW  = 8'h08;
	localparam logic [7:0] RB_FLAG_USED = 8'h00;

	// register byte address bit that selects the register index
	localparam logic REG_CARD_PRESENT = 1'b0;

	typedef enum logic [4:0] {
		PH_IDLE, PH_CMD,
		PH_R_ID1, PH_R_ID2, PH_R_AMSB, PH_R_ALSB, PH_R_ACK1, PH_R_ACK2,
		PH_R_CMSB, PH_R_CLSB, PH_R_DATA, PH_R_CHK, PH_R_END,
		PH_W_ID1, PH_W_ID2, PH_W_AMSB, PH_W_ALSB, PH_W_DATA, PH_W_CHK,
		PH_W_ACK1, PH_W_ACK2, PH_W_END,
		PH_G_ID1, PH_G_ID2, PH_G_ACK1, PH_G_ACK2, PH_G_1, PH_G_2, PH_G_3, PH_G_4
	} phase_t;

	// byte of the formatted empty card at a given frame and offset
	function automatic logic [7:0] image_byte(input logic [FADDR_W-1:0] frame,
		input logic [OFS_W-1:0] ofs);
		logic [7:0] val;
		val = 8'hFF;
		if (frame == 10'd0 || frame == 10'd63) begin
			// header frame and its copy: "MC" and the xor of the frame
			if (ofs == 7'd0)       val = 8'h4D;
			else if (ofs == 7'd1)  val = 8'h43;
			else if (ofs == 7'd127) val = 8'h0E;
			else                   val = 8'h00;
		end else if (frame < 10'd16) begin
			// free directory entries
			if (ofs == 7'd0 || ofs == 7'd127)     val = 8'hA0;
			else if (ofs == 7'd8 || ofs == 7'd9) val = 8'hFF;
			else                                 val = 8'h00;
		end else if (frame < 10'd36) begin
			// unused broken-sector entries, xor of frame is zero
			if (ofs <= 7'd3 || ofs == 7'd8 || ofs == 7'd9) val = 8'hFF;
			else                                          val = 8'h00;
		end else if (frame < 10'd63) begin
			val = 8'h00;
		end
		return val;
	endfunction

endpackage

FILE: hw/rtl/mcsr_store.sv
// ----------------------------------------------------------------------------
// mcsr_store
// single-port card store with registered read and a format pass after reset
// ----------------------------------------------------------------------------
module mcsr_store import mcsr_pkg::*; #(
	parameter int STORE_AW    = 17,
	parameter int STORE_DEPTH = 131072
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [STORE_AW-1:0] addr,
	input  logic [7:0]          wdata,
	output logic [7:0]          rdata,
	output logic                fill_done
);

	logic [7:0]          mem [STORE_DEPTH];
	logic [STORE_AW-1:0] fill_cnt_q;
	logic                fill_done_q;
	logic [7:0]          rdata_q;
	logic                port_we;
	logic [STORE_AW-1:0] port_addr;
	logic [7:0]          port_wdata;

	// format pass owns the port until the whole store is written
	always_comb begin
		port_we    = !fill_done_q || wr_en;
		port_addr  = fill_done_q ? addr : fill_cnt_q;
		port_wdata = fill_done_q ? wdata :
			image_byte(FADDR_W'(fill_cnt_q[STORE_AW-1:OFS_W]), fill_cnt_q[OFS_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q  <= '0;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			if (fill_cnt_q == STORE_AW'(STORE_DEPTH - 1)) fill_done_q <= 1'b1;
			else fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (port_we) mem[port_addr] <= port_wdata;
		rdata_q <= mem[port_addr];
	end

	assign rdata     = rdata_q;
	assign fill_done = fill_done_q;

endmodule

FILE: hw/rtl/memory_card_serial_responder_top.sv
// ----------------------------------------------------------------------------
// memory_card_serial_responder_top
// byte-level responder for the serial memory card exchange
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid / s_tready  s_tdata[7:0] host_byte
//  m_*       out   m_tvalid / m_tready  m_tdata[7:0] reply_byte, m_tuser[0] acknowledge
//  apb       in    psel/penable/pready  card_present at byte address 0
//
//  the store read for the next state's address follows each accepted word
//  and comes before the next one is taken, so the store port sets the rate
//  after reset the store is formatted, one byte a cycle, and then read
//  once for the first address; no word is accepted in that time,
//  config writes are taken
//  the output register takes a new reply in the cycle the previous one
//  leaves m_tdata; a stalled m_tready holds the reply and then s_tready
// ----------------------------------------------------------------------------
module memory_card_serial_responder_top import mcsr_pkg::*; #(
	parameter int CARD_FRAMES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// host byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] host_byte
	// reply stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] reply_byte
	output logic [0:0]  m_tuser,   // [0] acknowledge
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FA_W        = $clog2(CARD_FRAMES);
	localparam int STORE_AW    = FA_W + OFS_W;
	localparam int STORE_DEPTH = CARD_FRAMES * FRAME_BYTES;

	// protocol state
	phase_t             phase_q;
	logic [FADDR_W-1:0] faddr_q;
	logic [OFS_W-1:0]   ofs_q;
	logic [7:0]         csum_q;
	logic [7:0]         prev_q;
	logic               no_write_q;
	logic               card_present_q;

	// read data for the current address is valid once the store has re-read it after any update
	logic               rd_fresh_q;

	// output register
	logic               m_tvalid_q;
	logic [7:0]         reply_q;
	logic               ack_q;

	// next-state logic
	phase_t             phase_d;
	logic [FADDR_W-1:0] faddr_d;
	logic [OFS_W-1:0]   ofs_d;
	logic [7:0]         csum_d;
	logic               no_write_d;
	logic [7:0]         rep_c;
	logic               ack_c;
	logic               st_we_c;
	logic [7:0]         data_v;
	logic               addr_ok;

	logic               accept;
	logic [7:0]         st_rdata;
	logic               st_ready;
	logic               cfg_wr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = rd_fresh_q && (!m_tvalid_q || m_tready);
	assign addr_ok  = ({1'b0, faddr_q} < (FADDR_W + 1)'(CARD_FRAMES));

	mcsr_store #(
		.STORE_AW    (STORE_AW),
		.STORE_DEPTH (STORE_DEPTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && st_we_c),
		.addr      ({faddr_q[FA_W-1:0], ofs_q}),
		.wdata     (s_tdata),
		.rdata     (st_rdata),
		.fill_done (st_ready)
	);

	// protocol step for the byte at s_tdata
	always_comb begin
		phase_d    = phase_q;
		faddr_d    = faddr_q;
		ofs_d      = ofs_q;
		csum_d     = csum_q;
		no_write_d = no_write_q;
		rep_c      = RB_IDLE;
		ack_c      = 1'b0;
		st_we_c    = 1'b0;
		data_v     = (phase_q == PH_R_DATA) ? (addr_ok ? st_rdata : RB_IDLE) : s_tdata;
		if (card_present_q) begin
			ack_c = 1'b1;
			unique case (phase_q)
				PH_CMD: begin
					rep_c = no_write_q ? RB_FLAG_NEW : RB_FLAG_USED;
					if (s_tdata == HB_READ)       phase_d = PH_R_ID1;
					else if (s_tdata == HB_WRITE) phase_d = PH_W_ID1;
					else if (s_tdata == HB_GETID) phase_d = PH_G_ID1;
					else begin
						ack_c   = 1'b0;
						phase_d = PH_IDLE;
					end
				end
				PH_R_ID1: begin rep_c = RB_ID1; phase_d = PH_R_ID2; end
				PH_W_ID1: begin rep_c = RB_ID1; phase_d = PH_W_ID2; end
				PH_G_ID1: begin rep_c = RB_ID1; phase_d = PH_G_ID2; end
				PH_R_ID2: begin rep_c = RB_ID2; phase_d = PH_R_AMSB; end
				PH_W_ID2: begin rep_c = RB_ID2; phase_d = PH_W_AMSB; end
				PH_G_ID2: begin rep_c = RB_ID2; phase_d = PH_G_ACK1; end
				PH_R_AMSB, PH_W_AMSB: begin
					rep_c   = RB_ZERO;
					faddr_d = {s_tdata[1:0], faddr_q[7:0]};
					phase_d = (phase_q == PH_R_AMSB) ? PH_R_ALSB : PH_W_ALSB;
				end
				PH_R_ALSB, PH_W_ALSB: begin
					rep_c   = prev_q;
					faddr_d = {faddr_q[9:8], s_tdata};
					ofs_d   = '0;
					phase_d = (phase_q == PH_R_ALSB) ? PH_R_ACK1 : PH_W_DATA;
				end
				PH_R_ACK1: begin rep_c = RB_ACK1; phase_d = PH_R_ACK2; end
				PH_W_ACK1: begin rep_c = RB_ACK1; phase_d = PH_W_ACK2; end
				PH_G_ACK1: begin rep_c = RB_ACK1; phase_d = PH_G_ACK2; end
				PH_R_ACK2: begin rep_c = RB_ACK2; phase_d = PH_R_CMSB; end
				PH_W_ACK2: begin rep_c = RB_ACK2; phase_d = PH_W_END; end
				PH_G_ACK2: begin rep_c = RB_ACK2; phase_d = PH_G_1; end
				PH_R_CMSB: begin rep_c = {6'd0, faddr_q[9:8]}; phase_d = PH_R_CLSB; end
				PH_R_CLSB: begin rep_c = faddr_q[7:0]; phase_d = PH_R_DATA; end
				PH_R_DATA, PH_W_DATA: begin
					if (phase_q == PH_R_DATA) begin
						rep_c = data_v;
					end else begin
						rep_c   = prev_q;
						st_we_c = addr_ok;
						if (ofs_q == '0) no_write_d = 1'b0;
					end
					// checksum opens with both address bytes
					if (ofs_q == '0) csum_d = {6'd0, faddr_q[9:8]} ^ faddr_q[7:0] ^ data_v;
					else             csum_d = csum_q ^ data_v;
					ofs_d = ofs_q + 1'b1;
					if (ofs_q == OFS_W'(FRAME_BYTES - 1))
						phase_d = (phase_q == PH_R_DATA) ? PH_R_CHK : PH_W_CHK;
				end
				PH_R_CHK: begin rep_c = csum_q; phase_d = PH_R_END; end
				PH_W_CHK: begin rep_c = csum_q; phase_d = PH_W_ACK1; end
				PH_R_END, PH_W_END: begin
					rep_c   = RB_END;
					ack_c   = 1'b0;
					phase_d = PH_IDLE;
				end
				PH_G_1: begin rep_c = RB_SIZE; phase_d = PH_G_2; end
				PH_G_2: begin rep_c = RB_ZERO; phase_d = PH_G_3; end
				PH_G_3: begin rep_c = RB_ZERO; phase_d = PH_G_4; end
				PH_G_4: begin rep_c = RB_SECTOR; phase_d = PH_CMD; end
				// idle and the unused codes wait for the access byte
				default: begin
					rep_c = RB_IDLE;
					if (s_tdata == HB_ACCESS) phase_d = PH_CMD;
					else begin
						ack_c   = 1'b0;
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			faddr_q    <= '0;
			ofs_q      <= '0;
			csum_q     <= '0;
			prev_q     <= '0;
			no_write_q <= 1'b1;
		end else if (accept) begin
			phase_q    <= phase_d;
			faddr_q    <= faddr_d;
			ofs_q      <= ofs_d;
			csum_q     <= csum_d;
			no_write_q <= no_write_d;
			prev_q     <= s_tdata;
		end
	end

	// store port re-reads the new address in the cycle after an update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_fresh_q <= 1'b0;
		else         rd_fresh_q <= st_ready && !accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 m_tvalid_q <= 1'b0;
		else if (accept)             m_tvalid_q <= 1'b1;
		else if (m_tready)           m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_q <= rep_c;
			ack_q   <= ack_c;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = reply_q;
	assign m_tuser[0] = ack_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CARD_PRESENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     card_present_q <= 1'b1;
		else if (cfg_wr) card_present_q <= pwdata[0];
	end

	assign prdata = (paddr[2] == REG_CARD_PRESENT) ? {31'd0, card_present_q} : 32'd0;

	// no byte is taken before the format pass ends
	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!st_ready |-> !s_tready)
		else $error("byte accepted during format pass");

	// a store read cycle separates two accepted bytes
	a_one_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("back-to-back accept without store read");

	// after the format pass the store is written only by write data bytes with a card present
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st_we_c) |-> (phase_q == PH_W_DATA && card_present_q))
		else $error("store write outside write data phase");

	// a waiting reply is held until taken
	a_reply_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> (m_tvalid_q && $stable(reply_q) && $stable(ack_q)))
		else $error("pending reply changed");

endmodule

FILE: test/memory_card_serial_responder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_card_serial_responder_tb
// self-checking bench for the memory card serial responder: host words go in
// on the s_* stream, a bit-exact model of the card predicts each reply word
// and acknowledge, and every m_* word is checked in order against it
// ----------------------------------------------------------------------------
module tb;
	import mcsr_pkg::*;

	localparam int CARD_FRAMES  = 1024;
	localparam int STORE_BYTES  = CARD_FRAMES * FRAME_BYTES;
	localparam int TOTAL_ITEMS  = 1450;
	// the store is formatted byte by byte after reset, so the quiet limit
	// has to cover a whole formatting pass
	localparam int QUIET_LIMIT  = 3 * STORE_BYTES;

	// register byte addresses
	localparam logic [2:0] REG_CARD    = 3'd0;
	localparam logic [2:0] REG_UNUSED  = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       ack;
	} card_reply_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] host_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;            // [7:0] reply_byte
	logic [0:0]  m_tuser;            // [0] acknowledge
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// card model state
	logic        card_present;
	phase_t      phase;
	logic [9:0]  card_frame;
	logic [6:0]  byte_ofs;
	logic [7:0]  frame_sum;
	logic [7:0]  prev_host;
	logic        fresh_card;
	logic [7:0]  card_mem [0:STORE_BYTES-1];

	card_reply_t pending_replies[$];
	logic [7:0]  script[$];
	logic [9:0]  written_frames[$];
	int          bytes_sent   = 0;
	int          fail_count   = 0;
	int          quiet_cycles = 0;
	bit          steady       = 1'b0;

	memory_card_serial_responder_top #(
		.CARD_FRAMES(CARD_FRAMES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// card model: one host word in, one reply word and acknowledge out
	// ------------------------------------------------------------------
	function automatic void card_answer(input logic [7:0] b, output logic [7:0] rep,
		output logic ack);
		logic [7:0]  v;
		logic [16:0] idx;
		rep = RB_IDLE;
		ack = 1'b0;
		// no card: open bus, only the last host word is tracked
		if (!card_present) begin
			prev_host = b;
			return;
		end
		ack = 1'b1;
		idx = {card_frame, byte_ofs};
		case (phase)
			PH_CMD: begin
				rep = fresh_card ? RB_FLAG_NEW : RB_FLAG_USED;
				if (b == HB_READ)       phase = PH_R_ID1;
				else if (b == HB_WRITE) phase = PH_W_ID1;
				else if (b == HB_GETID) phase = PH_G_ID1;
				else begin
					// unknown command drops back to idle
					ack = 1'b0;
					phase = PH_IDLE;
				end
			end
			PH_R_ID1, PH_W_ID1, PH_G_ID1: begin
				rep = RB_ID1;
				phase = phase_t'(phase + 1);
			end
			PH_R_ID2, PH_W_ID2, PH_G_ID2: begin
				rep = RB_ID2;
				phase = phase_t'(phase + 1);
			end
			PH_R_AMSB, PH_W_AMSB: begin
				rep = RB_ZERO;
				card_frame = {b[1:0], card_frame[7:0]};
				phase = phase_t'(phase + 1);
			end
			PH_R_ALSB, PH_W_ALSB: begin
				rep = prev_host;
				card_frame = {card_frame[9:8], b};
				byte_ofs = 7'd0;
				phase = phase_t'(phase + 1);
			end
			PH_R_ACK1, PH_W_ACK1, PH_G_ACK1: begin
				rep = RB_ACK1;
				phase = phase_t'(phase + 1);
			end
			PH_R_ACK2, PH_W_ACK2, PH_G_ACK2: begin
				rep = RB_ACK2;
				phase = phase_t'(phase + 1);
			end
			PH_R_CMSB: begin
				rep = {6'd0, card_frame[9:8]};
				phase = PH_R_CLSB;
			end
			PH_R_CLSB: begin
				rep = card_frame[7:0];
				phase = PH_R_DATA;
			end
			PH_R_DATA, PH_W_DATA: begin
				if (phase == PH_R_DATA) begin
					// frames past the card read as open bus
					v = (card_frame < CARD_FRAMES) ? card_mem[idx] : RB_IDLE;
					rep = v;
				end else begin
					v = b;
					if (byte_ofs == 7'd0)
						fresh_card = 1'b0;
					if (card_frame < CARD_FRAMES)
						card_mem[idx] = v;
					rep = prev_host;
				end
				if (byte_ofs == 7'd0)
					frame_sum = {6'd0, card_frame[9:8]} ^ card_frame[7:0] ^ v;
				else
					frame_sum = frame_sum ^ v;
				if (byte_ofs == 7'(FRAME_BYTES - 1)) begin
					byte_ofs = 7'd0;
					phase = phase_t'(phase + 1);
				end else begin
					byte_ofs = byte_ofs + 7'd1;
				end
			end
			PH_R_CHK: begin
				rep = frame_sum;
				phase = PH_R_END;
			end
			PH_W_CHK: begin
				// host checksum is taken without a check
				rep = frame_sum;
				phase = PH_W_ACK1;
			end
			PH_R_END, PH_W_END: begin
				rep = RB_END;
				ack = 1'b0;
				phase = PH_IDLE;
			end
			PH_G_1: begin
				rep = RB_SIZE;
				phase = PH_G_2;
			end
			PH_G_2, PH_G_3: begin
				rep = RB_ZERO;
				phase = phase_t'(phase + 1);
			end
			PH_G_4: begin
				// get-ID leaves the card waiting for another command
				rep = RB_SECTOR;
				phase = PH_CMD;
			end
			default: begin
				rep = RB_IDLE;
				if (b == HB_ACCESS) begin
					phase = PH_CMD;
				end else begin
					ack = 1'b0;
					phase = PH_IDLE;
				end
			end
		endcase
		prev_host = b;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// sender gap after a word: mostly none or short, a few long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// host words that the card ignores in content
	function automatic logic [7:0] filler();
		return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	function automatic logic [9:0] pick_frame();
		logic [9:0] landmarks [10] = '{10'd0, 10'd1, 10'd15, 10'd16, 10'd35, 10'd36,
			10'd62, 10'd63, 10'd64, 10'd1023};
		int r;
		r = $urandom_range(0, 99);
		if (r < 30 && written_frames.size() > 0)
			return written_frames[$urandom_range(0, written_frames.size() - 1)];
		if (r < 55) return 10'($urandom_range(0, 63));
		if (r < 80) return landmarks[$urandom_range(0, 9)];
		return 10'($urandom);
	endfunction

	function automatic logic [7:0] unknown_command();
		logic [7:0] c;
		do c = 8'($urandom);
		while (c == HB_READ || c == HB_WRITE || c == HB_GETID);
		return c;
	endfunction

	// address msb word: only the low two bits count, the rest is noise
	function automatic logic [7:0] address_msb(input logic [9:0] frame);
		return {($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom), frame[9:8]};
	endfunction

	task automatic add_read(input bit chained, input logic [9:0] frame);
		if (!chained) script.push_back(HB_ACCESS);
		script.push_back(HB_READ);
		repeat (2) script.push_back(filler());
		script.push_back(address_msb(frame));
		script.push_back(frame[7:0]);
		// ack pair, address echo, data, checksum and end word
		repeat (4 + FRAME_BYTES + 2) script.push_back(filler());
	endtask

	task automatic add_write(input bit chained, input logic [9:0] frame);
		logic [7:0] d;
		logic [7:0] sum;
		int         pattern;
		pattern = $urandom_range(0, 3);
		sum = {6'd0, frame[9:8]} ^ frame[7:0];
		if (!chained) script.push_back(HB_ACCESS);
		script.push_back(HB_WRITE);
		repeat (2) script.push_back(filler());
		script.push_back(address_msb(frame));
		script.push_back(frame[7:0]);
		for (int k = 0; k < FRAME_BYTES; k++) begin
			case (pattern)
				0: d = 8'h00;
				1: d = 8'hFF;
				2: d = 8'(k);
				default: d = 8'($urandom);
			endcase
			sum = sum ^ d;
			script.push_back(d);
		end
		// host checksum, sometimes wrong on purpose
		script.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : sum);
		repeat (3) script.push_back(filler());
		written_frames.push_back(frame);
	endtask

	task automatic add_get_id(input bit chained);
		if (!chained) script.push_back(HB_ACCESS);
		script.push_back(HB_GETID);
		repeat (8) script.push_back(filler());
	endtask

	// one host word: hold tvalid until taken, predict, then maybe a gap
	task automatic send_word(input logic [7:0] b);
		card_reply_t r;
		int          gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk);
		while (!s_tready);
		card_answer(b, r.data, r.ack);
		pending_replies.push_back(r);
		bytes_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every predicted reply has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write while the block is idle, then read back card_present
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (addr == REG_CARD)
			card_present = data[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		paddr   <= REG_CARD;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[0] !== card_present) begin
			$error("card_present mismatch: expected %0b, got %0b", card_present, prdata[0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// send the queued script; optionally pull the card out part way through
	task automatic play_script(input bit interrupt);
		int cut;
		cut = interrupt ? $urandom_range(1, script.size() - 1) : -1;
		for (int k = 0; k < script.size(); k++) begin
			if (k == cut) begin
				reg_write(REG_CARD, 32'd0);
				repeat ($urandom_range(1, 4)) send_word(8'($urandom));
				reg_write(REG_CARD, 32'd1);
			end
			send_word(script[k]);
		end
		script.delete();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// words in idle other than the access word: open-bus reply, no ack
	task automatic test_idle_noise();
		script = '{8'h00, 8'hFF, 8'h80};
		play_script(1'b0);
	endtask

	// get-ID, a second get-ID straight from the command phase, then an
	// unknown command that ends the exchange
	task automatic test_get_id_chain();
		add_get_id(1'b0);
		add_get_id(1'b1);
		script.push_back(8'h00);
		play_script(1'b0);
	endtask

	// no card: state is frozen, an unused register address is ignored
	task automatic test_card_absent();
		reg_write(REG_CARD, 32'd0);
		script = '{HB_ACCESS, HB_READ, 8'hFF};
		play_script(1'b0);
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_word(HB_ACCESS);
		reg_write(REG_CARD, 32'd1);
	endtask

	task automatic test_random_sessions();
		int r;
		int k;
		while (bytes_sent < TOTAL_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 14) begin
				add_read(1'b0, pick_frame());
			end else if (r < 28) begin
				add_write(1'b0, pick_frame());
			end else if (r < 52) begin
				add_get_id(1'b0);
				// follow up from the command phase without a new access word
				k = $urandom_range(0, 9);
				if (k < 2)      add_read(1'b1, pick_frame());
				else if (k < 4) add_write(1'b1, pick_frame());
				else if (k < 5) add_get_id(1'b1);
				else if (k < 6) script.push_back(unknown_command());
			end else if (r < 70) begin
				script.push_back(HB_ACCESS);
				script.push_back(unknown_command());
			end else if (r < 88) begin
				repeat ($urandom_range(1, 6)) script.push_back(8'($urandom));
			end else begin
				reg_write(REG_CARD, 32'd0);
				repeat ($urandom_range(1, 5)) script.push_back(8'($urandom));
				play_script(1'b0);
				reg_write(REG_UNUSED, 32'($urandom));
				reg_write(REG_CARD, 32'd1);
				continue;
			end
			play_script(r < 52 && $urandom_range(0, 11) == 0);
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// reply side: random stalls, mostly short, a few long, some free runs
	// ------------------------------------------------------------------
	initial begin : reply_sink
		int   run;
		int   r;
		logic rdy;
		run = 0;
		rdy = 1'b0;
		forever begin
			@(posedge clk);
			if (run == 0) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					rdy = 1'b0;
					run = $urandom_range(1, 3);
				end else if (r < 18) begin
					rdy = 1'b0;
					run = $urandom_range(10, 40);
				end else if (r < 23) begin
					rdy = 1'b1;
					run = $urandom_range(50, 200);
				end else begin
					rdy = 1'b1;
					run = $urandom_range(1, 12);
				end
			end
			m_tready <= rdy;
			run--;
		end
	end

	// every reply word against the oldest prediction
	always @(posedge clk) begin : reply_check
		card_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("reply word with no prediction: reply_byte %02h acknowledge %0b",
					m_tdata, m_tuser[0]);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata !== want.data) begin
					$error("reply_byte mismatch: expected %02h, got %02h", want.data, m_tdata);
					fail_count++;
				end
				if (m_tuser[0] !== want.ack) begin
					$error("acknowledge mismatch: expected %0b, got %0b", want.ack, m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any word or register access moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("memory_card_serial_responder_top test failed");
			$finish;
		end
	end

	initial begin : main
		int base;
		logic [7:0] x;
		// formatted empty card: header, directory, broken-sector list, zero
		// frames up to 62, header copy at 63, erased bytes after that
		for (int a = 0; a < STORE_BYTES; a++)
			card_mem[a] = (a < 63 * FRAME_BYTES) ? 8'h00 : 8'hFF;
		card_mem[0] = 8'h4D;
		card_mem[1] = 8'h43;
		for (int fr = 1; fr < 16; fr++) begin
			base = fr * FRAME_BYTES;
			card_mem[base]     = 8'hA0;
			card_mem[base + 8] = 8'hFF;
			card_mem[base + 9] = 8'hFF;
		end
		for (int fr = 16; fr < 36; fr++) begin
			base = fr * FRAME_BYTES;
			for (int k = 0; k < 4; k++) card_mem[base + k] = 8'hFF;
			card_mem[base + 8] = 8'hFF;
			card_mem[base + 9] = 8'hFF;
		end
		for (int fr = 0; fr < 36; fr++) begin
			base = fr * FRAME_BYTES;
			x = 8'h00;
			for (int k = 0; k < FRAME_BYTES - 1; k++) x = x ^ card_mem[base + k];
			card_mem[base + FRAME_BYTES - 1] = x;
		end
		for (int k = 0; k < FRAME_BYTES; k++)
			card_mem[63 * FRAME_BYTES + k] = card_mem[k];

		card_present = 1'b1;
		phase        = PH_IDLE;
		card_frame   = 10'd0;
		byte_ofs     = 7'd0;
		frame_sum    = 8'h00;
		prev_host    = 8'h00;
		fresh_card   = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_noise();
		test_get_id_chain();
		test_card_absent();
		test_random_sessions();

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("memory_card_serial_responder_top test passed");
		else
			$display("memory_card_serial_responder_top test failed");
		$finish;
	end

endmodule
